>>> design/rrq_pkg.sv
// shared types and constants for the round-robin ready queue
package rrq_pkg;

    localparam int MAX_PROCS_DEF = 16;
    localparam int ID_W          = 32;
    localparam int REQ_W         = 2;
    localparam int LIVE_W        = 5;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 72;

    // request codes carried on the input tuser
    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE = 2'd0,
        REQ_SCHED  = 2'd1,
        REQ_TERM   = 2'd2
    } t_req;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CREATE,
        ST_ROT_RD,
        ST_ROT_WR,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_HEAD_RD,
        ST_DONE
    } t_state;

    // one finished result, handed from the sequencer to the output register
    typedef struct packed {
        logic [LIVE_W-1:0] live_count;
        logic [ID_W-1:0]   running_id;
        logic              running_valid;
        logic              accepted;
        logic [ID_W-1:0]   result_id;
    } t_result;

endpackage

>>> design/round_robin_ready_queue.sv
// top level of the round-robin ready queue: core, id store and output register
//
// Input channel (s_*): one request per transfer. tuser carries the request
// kind (create, schedule tick, terminate), tdata the id to terminate.
// Output channel (m_*): exactly one result per request, in request order.
// Requests are handled one at a time by a sequencer over an id store with one
// write and one read port, kept as a ring buffer; s_tready is high only while
// it is idle.
// A terminate searches the live ids with one store read per entry searched,
// then moves each later entry down with one read and write per entry; when
// the head matches, it only advances the head.
// The next request can be taken in the cycle after the result is loaded.
// A finished result waits in the output register; while the receiver stalls,
// the sequencer can take and work one more request and then holds it.
// Reset clears the queue, the running mark and the output valid flag, and sets
// the id counter to one; the store itself needs no clearing pass.
module round_robin_ready_queue #(
    parameter int MAX_PROCS = rrq_pkg::MAX_PROCS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] target_id
    input  logic [rrq_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] req_type
    input  logic [rrq_pkg::REQ_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] result_id, [32] accepted, [33] running_valid,
    // [65:34] running_id, [70:66] live_count, [71] zero
    output logic [rrq_pkg::M_TDATA_W-1:0] m_tdata
);
    import rrq_pkg::*;

    localparam int AW = $clog2(MAX_PROCS);

    logic            w_res_valid;
    logic            w_res_ready;
    t_result         w_res;
    logic            w_mem_we;
    logic [AW-1:0]   w_mem_waddr;
    logic [ID_W-1:0] w_mem_wdata;
    logic [AW-1:0]   w_mem_raddr;
    logic [ID_W-1:0] w_mem_rdata;

    logic            r_m_valid;
    t_result         r_m_res;

    rrq_core #(
        .MAX_PROCS (MAX_PROCS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_tvalid),
        .o_req_ready (s_tready),
        .i_req_type  (s_tuser),
        .i_target_id (s_tdata),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    rrq_mem #(
        .DEPTH (MAX_PROCS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // output register takes a result when empty or being drained
    assign w_res_ready = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_m_res <= w_res;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = M_TDATA_W'(r_m_res);

endmodule

>>> design/rrq_mem.sv
// id storage: one write port, one read port with registered read data
module rrq_mem #(
    parameter int DEPTH = rrq_pkg::MAX_PROCS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [rrq_pkg::ID_W-1:0] i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [rrq_pkg::ID_W-1:0] o_rdata
);
    import rrq_pkg::*;

    logic [ID_W-1:0] r_mem [DEPTH];
    logic [ID_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/rrq_core.sv
// sequencer and datapath: ring buffer pointers, search and compaction over the id store
module rrq_core #(
    parameter int MAX_PROCS = rrq_pkg::MAX_PROCS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request side
    input  logic                         i_req_valid,
    output logic                         o_req_ready,
    input  logic [rrq_pkg::REQ_W-1:0]    i_req_type,
    input  logic [rrq_pkg::ID_W-1:0]     i_target_id,
    // result side
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output rrq_pkg::t_result             o_res,
    // id store
    output logic                         o_mem_we,
    output logic [$clog2(MAX_PROCS)-1:0] o_mem_waddr,
    output logic [rrq_pkg::ID_W-1:0]     o_mem_wdata,
    output logic [$clog2(MAX_PROCS)-1:0] o_mem_raddr,
    input  logic [rrq_pkg::ID_W-1:0]     i_mem_rdata
);
    import rrq_pkg::*;

    localparam int AW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int SW = AW + 2;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_len, n_len;
    logic            r_run, n_run;
    logic [ID_W-1:0] r_cnt, n_cnt;
    logic [ID_W-1:0] r_target, n_target;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_ok, n_ok;
    logic [ID_W-1:0] r_resid, n_resid;

    logic [CW-1:0]   w_off;
    logic [SW-1:0]   w_sum;
    logic [AW-1:0]   w_phys;
    logic [AW-1:0]   w_head_inc;
    logic            w_match;

    // shared unit: logical offset from head to physical slot, modulo depth
    assign w_sum  = SW'(r_head) + SW'(w_off);
    assign w_phys = (w_sum >= SW'(MAX_PROCS)) ? AW'(w_sum - SW'(MAX_PROCS)) : AW'(w_sum);

    assign w_head_inc = (r_head == AW'(MAX_PROCS - 1)) ? '0 : r_head + AW'(1);
    assign w_match    = (i_mem_rdata == r_target);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_len   <= '0;
            r_run   <= 1'b0;
            r_cnt   <= ID_W'(1);
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_len   <= n_len;
            r_run   <= n_run;
            r_cnt   <= n_cnt;
        end
    end

    // per-request working registers
    always_ff @(posedge i_clk) begin
        r_target <= n_target;
        r_idx    <= n_idx;
        r_ok     <= n_ok;
        r_resid  <= n_resid;
    end

    // next state and store accesses
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_len       = r_len;
        n_run       = r_run;
        n_cnt       = r_cnt;
        n_target    = r_target;
        n_idx       = r_idx;
        n_ok        = r_ok;
        n_resid     = r_resid;
        w_off       = r_len;
        o_mem_we    = 1'b0;
        o_mem_waddr = w_phys;
        o_mem_wdata = r_cnt;
        o_mem_raddr = r_head;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_target = i_target_id;
                    n_idx    = '0;
                    n_ok     = 1'b0;
                    n_resid  = '0;
                    unique case (t_req'(i_req_type))
                        REQ_CREATE: n_state = ST_CREATE;
                        REQ_SCHED:  n_state = ST_ROT_RD;
                        REQ_TERM:   n_state = ST_SRCH_RD;
                        default:    n_state = ST_HEAD_RD;
                    endcase
                end
            end
            // append the counter value at the tail, unless the queue is full
            ST_CREATE: begin
                w_off = r_len;
                if (r_len < CW'(MAX_PROCS)) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = r_cnt;
                    n_len       = r_len + CW'(1);
                    n_cnt       = r_cnt + ID_W'(1);
                    n_resid     = r_cnt;
                    n_ok        = 1'b1;
                end
                n_state = ST_HEAD_RD;
            end
            // rotate a running head to the tail; otherwise mark the head running
            ST_ROT_RD: begin
                o_mem_raddr = r_head;
                if (r_len == '0) begin
                    n_state = ST_HEAD_RD;
                end else if (!r_run) begin
                    n_run   = 1'b1;
                    n_state = ST_HEAD_RD;
                end else begin
                    n_state = ST_ROT_WR;
                end
            end
            ST_ROT_WR: begin
                w_off       = r_len;
                o_mem_we    = 1'b1;
                o_mem_wdata = i_mem_rdata;
                n_head      = w_head_inc;
                n_state     = ST_HEAD_RD;
            end
            // linear search from the head, one entry per read and compare
            ST_SRCH_RD: begin
                w_off       = r_idx;
                o_mem_raddr = w_phys;
                if (r_idx >= r_len) begin
                    n_state = ST_HEAD_RD;
                end else begin
                    n_state = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                if (w_match) begin
                    n_ok = 1'b1;
                    if (r_idx == '0) begin
                        // removing the head: just advance it
                        n_run   = 1'b0;
                        n_head  = w_head_inc;
                        n_len   = r_len - CW'(1);
                        n_state = ST_HEAD_RD;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = ST_SH_RD;
                    end
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = ST_SRCH_RD;
                end
            end
            // close the gap: move each later entry down by one
            ST_SH_RD: begin
                w_off       = r_idx;
                o_mem_raddr = w_phys;
                if (r_idx >= r_len) begin
                    n_len   = r_len - CW'(1);
                    n_state = ST_HEAD_RD;
                end else begin
                    n_state = ST_SH_WR;
                end
            end
            ST_SH_WR: begin
                w_off       = r_idx - CW'(1);
                o_mem_we    = 1'b1;
                o_mem_wdata = i_mem_rdata;
                n_idx       = r_idx + CW'(1);
                n_state     = ST_SH_RD;
            end
            // fetch the head for the running id
            ST_HEAD_RD: begin
                o_mem_raddr = r_head;
                n_run       = r_run & (r_len != '0);
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                o_mem_raddr = r_head;
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result fields
    always_comb begin
        o_res.result_id     = r_resid;
        o_res.accepted      = r_ok;
        o_res.running_valid = r_run;
        o_res.running_id    = r_run ? i_mem_rdata : '0;
        o_res.live_count    = LIVE_W'(r_len);
    end

endmodule

>>> design/rrq_checker.sv
// port-level checks for the round-robin ready queue, bound to the top level
module rrq_port_checks (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [rrq_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [rrq_pkg::REQ_W-1:0]     s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rrq_pkg::M_TDATA_W-1:0] m_tdata
);
    import rrq_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time: busy right after a request transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // a refused request reports no id
    a_resid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == '0)
        else $error("result id without acceptance");

    // no running mark means no running id
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tdata[33] |-> m_tdata[65:34] == '0)
        else $error("running id without running mark");

    // reset empties the output
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind round_robin_ready_queue rrq_port_checks u_rrq_port_checks (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
